@@ hw/rtl/gamma_event_doppler_correction_assert.svh @@
// Assertion macros for the Doppler correction block.
`ifndef GAMMA_EVENT_DOPPLER_CORRECTION_ASSERT_SVH
`define GAMMA_EVENT_DOPPLER_CORRECTION_ASSERT_SVH
`ifndef SYNTH
`define GEDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GEDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GEDC_ASSERT(label, clk, rst, prop, msg)
`define GEDC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/gedc_pkg.sv @@
package gedc_pkg;

   localparam int unsigned MAX_HITS_DEFAULT = 32;
   localparam int unsigned FOLD_WIDTH       = 6;
   localparam int unsigned ENERGY_WIDTH     = 20;
   localparam int unsigned SUM_WIDTH        = 24;
   localparam int unsigned POS_WIDTH        = 16;
   localparam int unsigned BETA_WIDTH       = 16;
   localparam int unsigned VEC_WIDTH        = 18;
   localparam int unsigned CSR_INDEX_WIDTH  = 2;
   localparam int unsigned CSR_DATA_WIDTH   = 16;
   localparam int unsigned QUEUE_DEPTH      = 2;

   typedef logic [FOLD_WIDTH-1:0]          fold_type;
   typedef logic [SUM_WIDTH-1:0]           sum_type;
   typedef logic [ENERGY_WIDTH-1:0]        energy_type;
   typedef logic signed [POS_WIDTH-1:0]    pos_type;
   typedef logic signed [VEC_WIDTH-1:0]    vec_type;
   typedef logic signed [VEC_WIDTH-1:0]    beta_type;
   typedef logic [BETA_WIDTH-1:0]          ubeta_type;

   localparam sum_type   SUM_MAX          = '1;
   localparam ubeta_type BETA_AVG_RESET   = 16'd28147;
   localparam ubeta_type BETA_TOF_RESET   = 16'd28147;
   localparam pos_type   DECAY_Z_RESET    = 16'sd0;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BETA_AVG = 2'd0,
      CSR_BETA_TOF = 2'd1,
      CSR_DECAY_Z  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BETA_RANGE  = 2'd1,
      STATUS_ZERO_VECTOR = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAC, ST_CHECK, ST_SQRT1, ST_SQRT2, ST_DEN, ST_DIV1_SETUP,
      ST_DIV1, ST_FACT, ST_BB, ST_SQRTG, ST_MULLO, ST_MULHI, ST_DIV2_SETUP,
      ST_DIV2, ST_DONE
   } back_state_type;

   typedef struct packed {
      fold_type   fold;
      sum_type    total;
      energy_type peak;
      vec_type    ax;
      vec_type    ay;
      vec_type    az;
      vec_type    bx;
      vec_type    by;
      vec_type    bz;
      beta_type   beta;
   } job_type;

   typedef struct packed {
      fold_type   hit_fold;
      sum_type    summed_energy;
      energy_type peak_energy;
      sum_type    doppler_energy;
      logic       single_hit;
      status_type status;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hw/rtl/gedc_front.sv @@
module gedc_front #(
   parameter int unsigned MAX_HITS = gedc_pkg::MAX_HITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  gedc_pkg::energy_type      req_hit_energy,
   input  gedc_pkg::pos_type         req_crystal_x,
   input  gedc_pkg::pos_type         req_crystal_y,
   input  gedc_pkg::pos_type         req_crystal_z,
   input  gedc_pkg::pos_type         req_vertex_x,
   input  gedc_pkg::pos_type         req_vertex_y,
   input  gedc_pkg::pos_type         req_vertex_z,
   input  gedc_pkg::pos_type         req_track_x,
   input  gedc_pkg::pos_type         req_track_y,
   input  gedc_pkg::pos_type         req_track_z,
   input  gedc_pkg::ubeta_type       req_measured_beta,
   input  logic                      req_last_hit,
   input  gedc_pkg::ubeta_type       beta_avg,
   input  gedc_pkg::ubeta_type       beta_tof,
   input  gedc_pkg::pos_type         decay_z,
   input  gedc_pkg::queue_status_type q_status,
   output logic                      push,
   output gedc_pkg::job_type         job
);

   localparam gedc_pkg::fold_type FoldMax = gedc_pkg::fold_type'(MAX_HITS);

   gedc_pkg::fold_type   fold_ff, fold_in, fold_next;
   gedc_pkg::sum_type    total_ff, total_in, total_next;
   gedc_pkg::energy_type peak_ff, peak_in, peak_next;
   logic                 peak_valid_ff, peak_valid_in;
   gedc_pkg::pos_type    px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   gedc_pkg::pos_type    px_next, py_next, pz_next;
   logic [gedc_pkg::SUM_WIDTH:0] sum_wide;
   logic                 take, accept;
   gedc_pkg::vec_type    vx, vy, vz, dz;

   assign req_stall = q_status.full;
   assign accept    = req_valid & ~q_status.full;
   assign push      = accept & req_last_hit;

   always_comb begin
      fold_next  = (fold_ff < FoldMax) ? fold_ff + 1'b1 : fold_ff;
      sum_wide   = {1'b0, total_ff} + (gedc_pkg::SUM_WIDTH + 1)'(req_hit_energy);
      total_next = sum_wide[gedc_pkg::SUM_WIDTH] ? gedc_pkg::SUM_MAX
                                                 : sum_wide[gedc_pkg::SUM_WIDTH-1:0];
      take       = ~peak_valid_ff | (req_hit_energy > peak_ff);
      peak_next  = take ? req_hit_energy : peak_ff;
      px_next    = take ? req_crystal_x : px_ff;
      py_next    = take ? req_crystal_y : py_ff;
      pz_next    = take ? req_crystal_z : pz_ff;

      fold_in       = fold_ff;
      total_in      = total_ff;
      peak_in       = peak_ff;
      peak_valid_in = peak_valid_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      if (accept) begin
         if (req_last_hit) begin
            fold_in       = '0;
            total_in      = '0;
            peak_in       = '0;
            peak_valid_in = 1'b0;
            px_in         = '0;
            py_in         = '0;
            pz_in         = '0;
         end else begin
            fold_in       = fold_next;
            total_in      = total_next;
            peak_in       = peak_next;
            peak_valid_in = 1'b1;
            px_in         = px_next;
            py_in         = py_next;
            pz_in         = pz_next;
         end
      end
   end

   // vectors from the vertex, z shifted to the average decay point
   always_comb begin
      vx = gedc_pkg::vec_type'(req_vertex_x);
      vy = gedc_pkg::vec_type'(req_vertex_y);
      vz = gedc_pkg::vec_type'(req_vertex_z);
      dz = gedc_pkg::vec_type'(decay_z);
      job.fold  = fold_next;
      job.total = total_next;
      job.peak  = peak_next;
      job.ax    = gedc_pkg::vec_type'(px_next) - vx;
      job.ay    = gedc_pkg::vec_type'(py_next) - vy;
      job.az    = gedc_pkg::vec_type'(pz_next) - vz - dz;
      job.bx    = gedc_pkg::vec_type'(req_track_x) - vx;
      job.by    = gedc_pkg::vec_type'(req_track_y) - vy;
      job.bz    = gedc_pkg::vec_type'(req_track_z) - vz - dz;
      job.beta  = $signed({2'b00, req_measured_beta}) + $signed({2'b00, beta_avg})
                - $signed({2'b00, beta_tof});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff       <= '0;
         total_ff      <= '0;
         peak_ff       <= '0;
         peak_valid_ff <= 1'b0;
         px_ff         <= '0;
         py_ff         <= '0;
         pz_ff         <= '0;
      end else begin
         fold_ff       <= fold_in;
         total_ff      <= total_in;
         peak_ff       <= peak_in;
         peak_valid_ff <= peak_valid_in;
         px_ff         <= px_in;
         py_ff         <= py_in;
         pz_ff         <= pz_in;
      end
   end

endmodule

@@ hw/rtl/gedc_queue.sv @@
module gedc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gedc_pkg::job_type          push_job,
   input  logic                       pop,
   output gedc_pkg::job_type          pop_job,
   output gedc_pkg::queue_status_type q_status
);

   localparam int unsigned PtrWidth = $clog2(gedc_pkg::QUEUE_DEPTH);

   gedc_pkg::job_type      entry_ff [gedc_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrWidth + 1)'(push) - (PtrWidth + 1)'(pop);
      q_status.full  = (count_ff == (PtrWidth + 1)'(gedc_pkg::QUEUE_DEPTH));
      q_status.empty = (count_ff == '0);
      pop_job = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/gedc_back.sv @@
`include "gamma_event_doppler_correction_assert.svh"

module gedc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gedc_pkg::queue_status_type q_status,
   input  gedc_pkg::job_type          pop_job,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output gedc_pkg::result_type       result
);

   gedc_pkg::back_state_type state_ff, state_in;
   gedc_pkg::job_type        job_ff, job_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic [35:0]              s1_ff, s1_in, s2_ff, s2_in;
   logic signed [36:0]       dot_ff, dot_in;
   logic [25:0]              l1_ff, l1_in, l2_ff, l2_in;
   logic [52:0]              div_ff, div_in, rem_ff, rem_in;
   logic [23:0]              low_ff, low_in, quo_ff, quo_in;
   logic [63:0]              v_ff, v_in, r_ff, r_in;
   logic [16:0]              mag_ff, mag_in;
   logic [33:0]              f_ff, f_in;
   logic [31:0]              g_ff, g_in;
   logic [57:0]              prod_ff, prod_in;
   gedc_pkg::sum_type        corr_ff, corr_in;
   gedc_pkg::status_type     status_ff, status_in;
   gedc_pkg::result_type     res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   gedc_pkg::vec_type        op_a, op_b;
   logic signed [35:0]       mprod;
   logic signed [36:0]       mprod_ext;
   logic [63:0]              sq_bit, sq_sum, v_step, r_step;
   logic                     sq_ge;
   logic [52:0]              rem2, rem_step;
   logic                     dv_ge;
   logic [23:0]              quo_step;
   logic [51:0]              num1;
   logic [57:0]              num2;
   logic [32:0]              bm, gsub;
   logic [31:0]              bb;
   logic [32:0]              two_g;

   // shared square root step: one result bit per cycle
   always_comb begin
      sq_bit = 64'd1 << {cnt_ff, 1'b0};
      sq_sum = r_ff + sq_bit;
      sq_ge  = (v_ff >= sq_sum);
      v_step = sq_ge ? v_ff - sq_sum : v_ff;
      r_step = sq_ge ? (r_ff >> 1) + sq_bit : (r_ff >> 1);
   end

   // shared restoring divider step: one quotient bit per cycle
   always_comb begin
      rem2     = {rem_ff[51:0], low_ff[23]};
      dv_ge    = (rem2 >= div_ff);
      rem_step = dv_ge ? rem2 - div_ff : rem2;
      quo_step = {quo_ff[22:0], dv_ge};
   end

   always_comb begin
      case (cnt_ff[3:0])
         4'd0:    begin op_a = job_ff.ax; op_b = job_ff.ax; end
         4'd1:    begin op_a = job_ff.ay; op_b = job_ff.ay; end
         4'd2:    begin op_a = job_ff.az; op_b = job_ff.az; end
         4'd3:    begin op_a = job_ff.bx; op_b = job_ff.bx; end
         4'd4:    begin op_a = job_ff.by; op_b = job_ff.by; end
         4'd5:    begin op_a = job_ff.bz; op_b = job_ff.bz; end
         4'd6:    begin op_a = job_ff.ax; op_b = job_ff.bx; end
         4'd7:    begin op_a = job_ff.ay; op_b = job_ff.by; end
         default: begin op_a = job_ff.az; op_b = job_ff.bz; end
      endcase
      mprod     = op_a * op_b;
      mprod_ext = mprod;
   end

   always_comb begin
      num1  = (dot_ff[36] ? 52'(-dot_ff) : 52'(dot_ff)) << 16;
      bm    = job_ff.beta[15:0] * mag_ff;
      bb    = job_ff.beta[15:0] * job_ff.beta[15:0];
      gsub  = 33'h1_0000_0000 - 33'(bb);
      two_g = {g_ff, 1'b0};
      num2  = prod_ff + 58'(g_ff);
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cnt_in    = cnt_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      dot_in    = dot_ff;
      l1_in     = l1_ff;
      l2_in     = l2_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      quo_in    = quo_ff;
      v_in      = v_ff;
      r_in      = r_ff;
      mag_in    = mag_ff;
      f_in      = f_ff;
      g_in      = g_ff;
      prod_in   = prod_ff;
      corr_in   = corr_ff;
      status_in = status_ff;
      res_in    = res_ff;
      pop       = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         gedc_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               job_in   = pop_job;
               cnt_in   = '0;
               s1_in    = '0;
               s2_in    = '0;
               dot_in   = '0;
               state_in = gedc_pkg::ST_MAC;
            end
         end
         gedc_pkg::ST_MAC: begin
            if (cnt_ff < 5'd3)      s1_in  = s1_ff + $unsigned(mprod);
            else if (cnt_ff < 5'd6) s2_in  = s2_ff + $unsigned(mprod);
            else                    dot_in = dot_ff + mprod_ext;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd8) state_in = gedc_pkg::ST_CHECK;
         end
         gedc_pkg::ST_CHECK: begin
            corr_in = '0;
            if (job_ff.beta[17] || job_ff.beta[16]) begin
               status_in = gedc_pkg::STATUS_BETA_RANGE;
               state_in  = gedc_pkg::ST_DONE;
            end else if (s1_ff == '0 || s2_ff == '0) begin
               status_in = gedc_pkg::STATUS_ZERO_VECTOR;
               state_in  = gedc_pkg::ST_DONE;
            end else begin
               status_in = gedc_pkg::STATUS_OK;
               v_in      = 64'(s1_ff) << 16;
               r_in      = '0;
               cnt_in    = 5'd31;
               state_in  = gedc_pkg::ST_SQRT1;
            end
         end
         gedc_pkg::ST_SQRT1: begin
            v_in   = v_step;
            r_in   = r_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               l1_in    = r_step[25:0];
               v_in     = 64'(s2_ff) << 16;
               r_in     = '0;
               cnt_in   = 5'd31;
               state_in = gedc_pkg::ST_SQRT2;
            end
         end
         gedc_pkg::ST_SQRT2: begin
            v_in   = v_step;
            r_in   = r_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               l2_in    = r_step[25:0];
               state_in = gedc_pkg::ST_DEN;
            end
         end
         gedc_pkg::ST_DEN: begin
            div_in   = 53'(l1_ff) * 53'(l2_ff);
            state_in = gedc_pkg::ST_DIV1_SETUP;
         end
         gedc_pkg::ST_DIV1_SETUP: begin
            // quotient at or above 2^18 clamps anyway
            if (53'(num1[51:18]) >= div_ff) begin
               mag_in   = 17'h10000;
               state_in = gedc_pkg::ST_FACT;
            end else begin
               rem_in   = 53'(num1[51:18]);
               low_in   = {num1[17:0], 6'd0};
               quo_in   = '0;
               cnt_in   = 5'd17;
               state_in = gedc_pkg::ST_DIV1;
            end
         end
         gedc_pkg::ST_DIV1: begin
            rem_in = rem_step;
            low_in = low_ff << 1;
            quo_in = quo_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               mag_in   = (quo_step[17:0] > 18'h10000) ? 17'h10000 : quo_step[16:0];
               state_in = gedc_pkg::ST_FACT;
            end
         end
         gedc_pkg::ST_FACT: begin
            f_in     = dot_ff[36] ? 34'h1_0000_0000 + 34'(bm)
                                  : 34'h1_0000_0000 - 34'(bm);
            state_in = gedc_pkg::ST_BB;
         end
         gedc_pkg::ST_BB: begin
            v_in     = 64'(gsub) << 30;
            r_in     = '0;
            cnt_in   = 5'd31;
            state_in = gedc_pkg::ST_SQRTG;
         end
         gedc_pkg::ST_SQRTG: begin
            v_in   = v_step;
            r_in   = r_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               g_in     = r_step[31:0];
               state_in = gedc_pkg::ST_MULLO;
            end
         end
         gedc_pkg::ST_MULLO: begin
            prod_in  = 58'(job_ff.total) * 58'(f_ff[16:0]);
            state_in = gedc_pkg::ST_MULHI;
         end
         gedc_pkg::ST_MULHI: begin
            prod_in  = prod_ff + ((58'(job_ff.total) * 58'(f_ff[33:17])) << 17);
            state_in = gedc_pkg::ST_DIV2_SETUP;
         end
         gedc_pkg::ST_DIV2_SETUP: begin
            div_in = 53'(two_g);
            if (34'(num2[57:24]) >= 34'(two_g)) begin
               corr_in  = gedc_pkg::SUM_MAX;
               state_in = gedc_pkg::ST_DONE;
            end else begin
               rem_in   = 53'(num2[57:24]);
               low_in   = num2[23:0];
               quo_in   = '0;
               cnt_in   = 5'd23;
               state_in = gedc_pkg::ST_DIV2;
            end
         end
         gedc_pkg::ST_DIV2: begin
            rem_in = rem_step;
            low_in = low_ff << 1;
            quo_in = quo_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               corr_in  = quo_step;
               state_in = gedc_pkg::ST_DONE;
            end
         end
         gedc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               res_in.hit_fold       = job_ff.fold;
               res_in.summed_energy  = job_ff.total;
               res_in.peak_energy    = job_ff.peak;
               res_in.doppler_energy = corr_ff;
               res_in.single_hit     = (job_ff.fold == gedc_pkg::fold_type'(1));
               res_in.status         = status_ff;
               rsp_valid_in          = 1'b1;
               state_in              = gedc_pkg::ST_IDLE;
            end
         end
         default: state_in = gedc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gedc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      dot_ff    <= dot_in;
      l1_ff     <= l1_in;
      l2_ff     <= l2_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      quo_ff    <= quo_in;
      v_ff      <= v_in;
      r_ff      <= r_in;
      mag_ff    <= mag_in;
      f_ff      <= f_in;
      g_ff      <= g_in;
      prod_ff   <= prod_in;
      corr_ff   <= corr_in;
      status_ff <= status_in;
      res_ff    <= res_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = res_ff;

   `GEDC_ASSERT(a_div_rem_below_divisor, clock, reset, (state_ff == gedc_pkg::ST_DIV1 || state_ff == gedc_pkg::ST_DIV2) |-> (rem_ff < div_ff), "divider remainder not below divisor")
   `GEDC_ASSERT(a_error_gives_zero, clock, reset, (state_ff == gedc_pkg::ST_DONE && status_ff != gedc_pkg::STATUS_OK) |-> (corr_ff == '0), "flagged event with nonzero energy")
   `GEDC_ASSERT(a_sqrt_counts_down, clock, reset, (state_ff == gedc_pkg::ST_SQRT1 && cnt_ff != '0) |=> (state_ff == gedc_pkg::ST_SQRT1 && cnt_ff == $past(cnt_ff) - 5'd1), "square root iteration skipped")
   `GEDC_ASSERT(a_result_has_hits, clock, reset, rsp_valid_ff |-> (res_ff.hit_fold != '0), "result with zero fold")

endmodule

@@ hw/rtl/gamma_event_doppler_correction.sv @@
// Gamma event Doppler correction.
// req_ channel: one crystal hit per transaction, taken when req_valid is high
// and req_stall is low. Hits without req_last_hit are absorbed into the event
// being gathered; the hit marked last closes the event and queues it for correction.
// rsp_ channel: one result per event, held while rsp_stall is high.
// A two-entry queue sits between the hit accumulator and the correction
// engine, so new hits are taken while an earlier event is still in work.
// The correction engine takes each event through 9 multiply-accumulate steps
// and, for a normal event, three 32-step square roots, an 18-step and a
// 24-step divide on one shared sequencer; a divide is skipped when the cosine
// or the result clamps, and a flagged event goes from the check straight to
// the result. It works on one event at a time; hits of later events are taken
// meanwhile, and req_stall rises only while the queue is full.
// csr_ channel: always ready; index 0 average beta, 1 mean TOF beta, 2 decay
// z shift; other indexes are ignored. Write only while the block is idle.
// Reset (synchronous, active high) clears the event being gathered, the queue
// and the output valid flag, and loads the register defaults.
module gamma_event_doppler_correction #(
   parameter int unsigned MAX_HITS = gedc_pkg::MAX_HITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [gedc_pkg::ENERGY_WIDTH-1:0]      req_hit_energy,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_crystal_x,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_crystal_y,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_crystal_z,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_vertex_x,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_vertex_y,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_vertex_z,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_track_x,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_track_y,
   input  logic signed [gedc_pkg::POS_WIDTH-1:0]  req_track_z,
   input  logic [gedc_pkg::BETA_WIDTH-1:0]        req_measured_beta,
   input  logic                                   req_last_hit,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [gedc_pkg::FOLD_WIDTH-1:0]        rsp_hit_fold,
   output logic [gedc_pkg::SUM_WIDTH-1:0]         rsp_summed_energy,
   output logic [gedc_pkg::ENERGY_WIDTH-1:0]      rsp_peak_energy,
   output logic [gedc_pkg::SUM_WIDTH-1:0]         rsp_doppler_energy,
   output logic                                   rsp_single_hit,
   output logic [1:0]                             rsp_status,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gedc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gedc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   gedc_pkg::ubeta_type        beta_avg_ff, beta_avg_in, beta_tof_ff, beta_tof_in;
   gedc_pkg::pos_type          decay_z_ff, decay_z_in;
   gedc_pkg::queue_status_type q_status;
   gedc_pkg::job_type          push_job, pop_job;
   gedc_pkg::result_type       result;
   logic                       push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      beta_avg_in = beta_avg_ff;
      beta_tof_in = beta_tof_ff;
      decay_z_in  = decay_z_ff;
      if (csr_valid) begin
         case (csr_index)
            gedc_pkg::CSR_BETA_AVG: beta_avg_in = csr_data;
            gedc_pkg::CSR_BETA_TOF: beta_tof_in = csr_data;
            gedc_pkg::CSR_DECAY_Z:  decay_z_in  = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_avg_ff <= gedc_pkg::BETA_AVG_RESET;
         beta_tof_ff <= gedc_pkg::BETA_TOF_RESET;
         decay_z_ff  <= gedc_pkg::DECAY_Z_RESET;
      end else begin
         beta_avg_ff <= beta_avg_in;
         beta_tof_ff <= beta_tof_in;
         decay_z_ff  <= decay_z_in;
      end
   end

   gedc_front #(
      .MAX_HITS (MAX_HITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_hit_energy    (req_hit_energy),
      .req_crystal_x     (req_crystal_x),
      .req_crystal_y     (req_crystal_y),
      .req_crystal_z     (req_crystal_z),
      .req_vertex_x      (req_vertex_x),
      .req_vertex_y      (req_vertex_y),
      .req_vertex_z      (req_vertex_z),
      .req_track_x       (req_track_x),
      .req_track_y       (req_track_y),
      .req_track_z       (req_track_z),
      .req_measured_beta (req_measured_beta),
      .req_last_hit      (req_last_hit),
      .beta_avg          (beta_avg_ff),
      .beta_tof          (beta_tof_ff),
      .decay_z           (decay_z_ff),
      .q_status          (q_status),
      .push              (push),
      .job               (push_job)
   );

   gedc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_status (q_status)
   );

   gedc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .result    (result)
   );

   assign rsp_hit_fold       = result.hit_fold;
   assign rsp_summed_energy  = result.summed_energy;
   assign rsp_peak_energy    = result.peak_energy;
   assign rsp_doppler_energy = result.doppler_energy;
   assign rsp_single_hit     = result.single_hit;
   assign rsp_status         = result.status;

endmodule
